// File: rtl/wfps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wall-follow PID steering block.
// No dependencies; imported by every module of the block.
package wfps_pkg;

    // Field widths
    localparam int SIDE_W   = 13;
    localparam int FRONT_W  = 16;
    localparam int BASE_W0  = 9;     // baseline in whole cm
    localparam int LIMIT_W  = 10;
    localparam int GAIN_W   = 16;
    localparam int ACT_W    = 2;
    localparam int DUTY_W   = 15;
    localparam int E_W      = 15;    // saturated error
    localparam int SUM_W    = 32;
    localparam int DIFF_W   = 16;
    localparam int OPB_W    = 33;    // second multiplier operand
    localparam int PROD_W   = GAIN_W + OPB_W;
    localparam int ACC_W    = 50;
    localparam int MAG_W    = ACC_W - 1;
    localparam int Q_W      = 16;    // quotient bits kept by the divider
    localparam int M_W      = Q_W + 1;
    localparam int D_W      = 19;    // signed duty before clipping

    // Stream packing
    localparam int IN_W     = 32;
    localparam int OUT_W    = 40;
    localparam int USER_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT    = 3'd4;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd384;
    localparam logic [LIMIT_W-1:0]       LIMIT_RST  = 10'd30;

    // Wheel commands
    localparam logic [ACT_W-1:0] ACT_HOLD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DRIVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;

    // Duty in 1/256 percent
    localparam logic [DUTY_W-1:0] DUTY_BASE   = 15'd15360;
    localparam logic [DUTY_W-1:0] DUTY_CRUISE = 15'd23040;
    localparam logic [DUTY_W-1:0] DUTY_FULL   = 15'd25600;

    // Scale factors folded into the P and D products
    localparam logic signed [OPB_W-1:0] P_SCALE = 33'sd10;
    localparam logic signed [OPB_W-1:0] D_SCALE = 33'sd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctrl;

    typedef struct packed {
        logic           done;
        logic           ovf;
        logic [Q_W-1:0] quot;
    } t_div_res;

endpackage

// File: rtl/wall_follow_pid_steering_top.sv
`timescale 1ns / 1ps
// Top level of the wall-follow PID steering block: sequencer, state, decision.
// Depends on wfps_pkg, wfps_mac and wfps_div.
//
// Usage
//   Input stream s_axis_*: one item per sensor sample (side and front distance).
//   Output stream m_axis_*: one item per input, both wheel commands and flags.
//   Config port i_cfg_*: writes baseline, P/I/D gains and front limit by index,
//   one register per cycle; the user must write only while the block is idle,
//   which the block itself does not enforce; indexes past the list are ignored.
//   An item runs through one shared multiply-accumulate unit (three products,
//   P, I and D) and then a one-bit-per-cycle divider for the 16-bit
//   correction; the divide is skipped when the baseline is zero.
//   s_axis_tready is low while an item is in flight, so a new item is taken
//   only after the last one has gone into the output register.
//   A finished item sits in the output register; the next item can be taken
//   while it waits, but the block will not finish that next one until the
//   receiver takes the first.
//   Reset (synchronous, active low) clears the error sum and last error,
//   loads the register defaults and empties the output.
module wall_follow_pid_steering_top import wfps_pkg::*; #(
    parameter int DIST_FRAC_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input samples
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // side_distance[12:0], front_range[28:13]
    // wheel commands
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // left_action[1:0], left_duty[16:2],
                                                  // right_action[18:17], right_duty[33:19]
    output logic [USER_W-1:0]     m_axis_tuser    // zero_baseline[0], duty_clipped[1]
);

    localparam int BASE_W = BASE_W0 + DIST_FRAC_BITS;
    localparam int EF_W   = (BASE_W > 14 ? BASE_W : 14) + 1;
    localparam logic signed [EF_W-1:0]  E_MAX  = EF_W'(16383);
    localparam logic signed [EF_W-1:0]  E_MIN  = EF_W'(-16384);
    localparam logic signed [E_W-1:0]   E_TWO  = E_W'(2 << DIST_FRAC_BITS);
    localparam logic signed [SUM_W:0]   S_MAX  = (SUM_W + 1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [SUM_W:0]   S_MIN  = (SUM_W + 1)'(33'sh1_8000_0000);
    localparam logic signed [D_W-1:0]   D_FULL = D_W'(DUTY_FULL);

    // config registers
    logic [BASE_W0-1:0]       r_baseline;
    logic signed [GAIN_W-1:0] r_gp, r_gi, r_gd;
    logic [LIMIT_W-1:0]       r_limit;

    // controller state
    t_state                   r_state, n_state;
    logic signed [E_W-1:0]    r_last;
    logic signed [SUM_W-1:0]  r_sum;

    // per-item working registers
    logic [SIDE_W-1:0]        r_side;
    logic [FRONT_W-1:0]       r_front;
    logic signed [E_W-1:0]    r_e;
    logic signed [SUM_W-1:0]  r_s;
    logic signed [DIFF_W-1:0] r_diff;

    // output register
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_tdata;
    logic [USER_W-1:0]        r_out_tuser;

    // datapath
    logic [BASE_W-1:0]        w_base_sh;
    logic signed [EF_W-1:0]   w_e_full;
    logic signed [E_W-1:0]    w_e;
    logic signed [SUM_W:0]    w_s_full;
    logic signed [SUM_W-1:0]  w_s;
    logic                     w_zero_b;

    t_mac_ctrl                w_mac_ctrl;
    logic signed [GAIN_W-1:0] w_mac_a;
    logic signed [OPB_W-1:0]  w_mac_b;
    logic signed [ACC_W-1:0]  w_acc;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_div_start;
    t_div_res                 w_div;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_load;

    // decision
    logic                     w_clear, w_blocked, w_close, w_far;
    logic [M_W-1:0]           w_m;
    logic                     w_sub;
    logic signed [D_W-1:0]    w_d;
    logic [DUTY_W-1:0]        w_duty;
    logic                     w_clip;
    logic [ACT_W-1:0]         w_la, w_ra;
    logic [DUTY_W-1:0]        w_ld, w_rd;
    logic                     w_zf, w_cf;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_zero_b   = (r_baseline == '0);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= '0;
            r_gp       <= GAIN_P_RST;
            r_gi       <= GAIN_I_RST;
            r_gd       <= GAIN_D_RST;
            r_limit    <= LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BASELINE: r_baseline <= i_cfg_data[BASE_W0-1:0];
                CFG_GAIN_P:   r_gp       <= i_cfg_data;
                CFG_GAIN_I:   r_gi       <= i_cfg_data;
                CFG_GAIN_D:   r_gd       <= i_cfg_data;
                CFG_FRONT:    r_limit    <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- error, sum, difference ----------------
    assign w_base_sh = BASE_W'(r_baseline) << DIST_FRAC_BITS;
    assign w_e_full  = $signed(EF_W'(w_base_sh)) - $signed(EF_W'(r_side));

    always_comb begin
        if (w_e_full > E_MAX) begin
            w_e = E_W'(E_MAX);
        end else if (w_e_full < E_MIN) begin
            w_e = E_W'(E_MIN);
        end else begin
            w_e = E_W'(w_e_full);
        end
    end

    assign w_s_full = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(w_e);

    always_comb begin
        if (w_s_full > S_MAX) begin
            w_s = SUM_W'(S_MAX);
        end else if (w_s_full < S_MIN) begin
            w_s = SUM_W'(S_MIN);
        end else begin
            w_s = SUM_W'(w_s_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_sum  <= '0;
        end else if (r_state == ST_ERR) begin
            r_last <= w_e;
            r_sum  <= w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_side  <= s_axis_tdata[SIDE_W-1:0];
            r_front <= s_axis_tdata[SIDE_W +: FRONT_W];
        end
        if (r_state == ST_ERR) begin
            r_e    <= w_e;
            r_s    <= w_s;
            r_diff <= DIFF_W'(w_e) - DIFF_W'(r_last);
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        w_mac_ctrl.clr = 1'b0;
        w_mac_ctrl.en  = 1'b0;
        w_mac_a        = '0;
        w_mac_b        = '0;
        w_div_start    = 1'b0;
        w_load         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                w_mac_ctrl.clr = 1'b1;
                n_state        = ST_MUL_P;
            end
            ST_MUL_P: begin
                w_mac_ctrl.en = 1'b1;
                w_mac_a       = r_gp;
                w_mac_b       = OPB_W'(r_e) * P_SCALE;
                n_state       = ST_MUL_I;
            end
            ST_MUL_I: begin
                w_mac_ctrl.en = 1'b1;
                w_mac_a       = r_gi;
                w_mac_b       = OPB_W'(r_s);
                n_state       = ST_MUL_D;
            end
            ST_MUL_D: begin
                w_mac_ctrl.en = 1'b1;
                w_mac_a       = r_gd;
                w_mac_b       = OPB_W'(r_diff) * D_SCALE;
                n_state       = ST_DRAIN;
            end
            ST_DRAIN: begin
                // last product lands in the accumulator
                n_state = ST_DIV_START;
            end
            ST_DIV_START: begin
                w_div_start = !w_zero_b;
                n_state     = w_zero_b ? ST_DONE : ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // ---------------- shared arithmetic ----------------
    wfps_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc)
    );

    assign w_mag = w_acc[ACC_W-1] ? MAG_W'(-w_acc) : MAG_W'(w_acc);

    wfps_div #(
        .DEN_W (BASE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mag),
        .i_den   (w_base_sh),
        .o_res   (w_div)
    );

    // ---------------- decision ----------------
    assign w_clear   = r_front >= FRONT_W'(r_limit);
    assign w_blocked = ((FRONT_W + 1)'(r_front) + (FRONT_W + 1)'(3)) < (FRONT_W + 1)'(r_limit);
    assign w_close   = (r_e > E_TWO) && w_clear;
    assign w_far     = (r_e < -E_TWO) && w_clear;

    always_comb begin
        // an overflowed quotient is at least 2^Q_W, which saturates either way
        if (w_zero_b) begin
            w_m = '0;
        end else if (w_div.ovf) begin
            w_m = M_W'(1) << Q_W;
        end else begin
            w_m = M_W'(w_div.quot);
        end
    end

    // one duty for the driving wheel: base - corr when acc sign ^ far, else base + corr
    assign w_sub = w_acc[ACC_W-1] ^ w_far;
    assign w_d   = w_sub ? (D_W'(DUTY_BASE) - D_W'(w_m)) : (D_W'(DUTY_BASE) + D_W'(w_m));

    always_comb begin
        if (w_d[D_W-1]) begin
            w_duty = '0;
            w_clip = 1'b1;
        end else if (w_d > D_FULL) begin
            w_duty = DUTY_FULL;
            w_clip = 1'b1;
        end else begin
            w_duty = w_d[DUTY_W-1:0];
            w_clip = 1'b0;
        end
    end

    always_comb begin
        w_la = ACT_HOLD;
        w_ld = '0;
        w_ra = ACT_HOLD;
        w_rd = '0;
        w_zf = 1'b0;
        w_cf = 1'b0;
        if (w_close) begin
            w_la = ACT_STOP;
            w_ra = ACT_DRIVE;
            w_rd = w_duty;
            w_zf = w_zero_b;
            w_cf = w_clip;
        end else if (w_far) begin
            w_la = ACT_DRIVE;
            w_ld = w_duty;
            w_ra = ACT_STOP;
            w_zf = w_zero_b;
            w_cf = w_clip;
        end else if (w_clear) begin
            w_la = ACT_DRIVE;
            w_ld = DUTY_CRUISE;
            w_ra = ACT_DRIVE;
            w_rd = DUTY_CRUISE;
        end else if (w_blocked) begin
            w_la = ACT_STOP;
            w_ra = ACT_STOP;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_tdata <= OUT_W'({w_rd, w_ra, w_ld, w_la});
            r_out_tuser <= {w_cf, w_zf};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule

// File: rtl/wfps_mac.sv
`timescale 1ns / 1ps
// Shared signed multiply-accumulate unit: registered product, then accumulate.
// Depends on wfps_pkg.
module wfps_mac import wfps_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [GAIN_W-1:0] i_a,
    input  logic signed [OPB_W-1:0]  i_b,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctrl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/wfps_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with an up-front overflow check.
// Depends on wfps_pkg.
module wfps_div import wfps_pkg::*; #(
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    localparam int CNT_W = $clog2(Q_W);
    localparam int DSH_W = DEN_W + Q_W - 1;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]   r_rem;
    logic [DSH_W-1:0]   r_dsh;
    logic [Q_W-1:0]     r_quot;
    logic               r_ovf;
    logic               w_ge;

    assign w_ge = r_rem >= MAG_W'(r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= DSH_W'(i_den) << (Q_W - 1);
            // quotient would not fit Q_W bits; caller saturates
            r_ovf  <= i_num >= (MAG_W'(i_den) << Q_W);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - MAG_W'(r_dsh);
            end
            r_quot <= {r_quot[Q_W-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;

endmodule

// File: rtl/wfps_checker.sv
`timescale 1ns / 1ps
// Port-level checks for wall_follow_pid_steering_top, attached by bind.
// Depends on wfps_pkg and the top level's port list.
module wfps_checker import wfps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [USER_W-1:0] m_axis_tuser
);

    logic [ACT_W-1:0]  la, ra;
    logic [DUTY_W-1:0] ld, rd;

    assign la = m_axis_tdata[1:0];
    assign ld = m_axis_tdata[16:2];
    assign ra = m_axis_tdata[18:17];
    assign rd = m_axis_tdata[33:19];

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled item changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    a_duty_when_driving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (la == ACT_DRIVE || ld == '0) && (ra == ACT_DRIVE || rd == '0)
            && ld <= DUTY_FULL && rd <= DUTY_FULL)
        else $error("duty out of range or set on a wheel not driving");

    a_clip_in_correction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[0]) |->
            (la == ACT_STOP && ra == ACT_DRIVE) || (la == ACT_DRIVE && ra == ACT_STOP))
        else $error("flag set outside a correction case");

endmodule

bind wall_follow_pid_steering_top wfps_checker u_wfps_checker (.*);
